[hw/rtl/krsa_pkg.sv]
// Package for the keyed record store allocator.
// Holds the store geometry, the command and status codes and the shared types.
// It has no dependencies.
package krsa_pkg;

  localparam int StoreBytes = 1024;
  localparam int AddrW = $clog2(StoreBytes);
  localparam int HdrBytes = 8;
  localparam logic [7:0] MarkerReset = 8'd82;

  typedef enum logic [2:0] {
    CMD_LOOKUP = 3'd0,
    CMD_EMPLACE = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_FORMAT = 3'd3,
    CMD_READ = 3'd4,
    CMD_WRITE = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_WRONG_KIND = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_BAD_REQ = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [31:0] key;
    logic [2:0] kind;
    logic [9:0] length;
    logic [9:0] byte_addr;
    logic [7:0] byte_data;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] found_kind;
    logic [9:0] payload_addr;
    logic [9:0] payload_size;
    logic [7:0] read_data;
  } rsp_t;

endpackage

[hw/rtl/krsa_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on krsa_pkg for the payload structs.
interface krsa_req_if (input logic clk);
  import krsa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface krsa_rsp_if (input logic clk);
  import krsa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/keyed_record_store_allocator_top.sv]
// Top level of the keyed record store allocator: sequencer and byte memory.
// Depends on krsa_pkg and the channel interfaces in krsa_if.sv.
//
// Usage: requests arrive on the req channel, one response leaves on the rsp
// channel for each request. The marker byte is written through the APB port
// at address 0 and read back there.
// One request is worked on at a time. The store is a single-port byte memory
// with a registered read, so each header byte takes an address state and then a
// capture state. A lookup, remove or emplace walk reads 8 bytes per record
// visited and evaluates each record after its last byte; emplace may walk twice
// (key, then free space or chain end) and writes up to 24 header bytes (an
// append that also frees the old record writes three headers). A byte read
// passes the byte and capture states before the response, a byte write only
// the byte state.
// After reset a clearing pass writes 0xFF to every byte, during which no request is
// accepted. The response sits in an output register; while the receiver stalls,
// the block holds it and takes no new request.
module keyed_record_store_allocator_top (
  input  logic clk,
  input  logic rst,
  krsa_req_if.sink req,
  krsa_rsp_if.source rsp,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import krsa_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_HADDR = 11'b00000000100,
    S_HCAP = 11'b00000001000,
    S_EVAL = 11'b00000010000,
    S_WRHDR = 11'b00000100000,
    S_BYTE = 11'b00001000000,
    S_BCAP = 11'b00010000000,
    S_DONE = 11'b00100000000,
    S_OUT = 11'b01000000000,
    S_DECIDE = 11'b10000000000
  } state_t;

  // Walk purposes.
  typedef enum logic [1:0] {
    W_KEY = 2'd0,
    W_FREE = 2'd1,
    W_END = 2'd2
  } walk_t;

  localparam int CntW = AddrW + 1;
  localparam logic [CntW-1:0] StoreLen = CntW'(StoreBytes);

  // Byte memory.
  logic [7:0] mem [StoreBytes];
  logic mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  state_t state;
  walk_t walk;
  req_t cur;
  rsp_t out_r;
  logic [7:0] marker;
  logic [CntW-1:0] pos;       // current header address, may reach StoreBytes
  logic [2:0] bi;             // header byte index
  logic [63:0] hdr;
  logic found, ffound;
  logic [AddrW-1:0] fa, fb;   // found key record, free record
  logic [15:0] fa_size;
  logic [7:0] fa_kind;
  // Header write queue: up to two headers.
  logic [1:0] wq;             // remaining headers: bit0 first, bit1 second
  logic [AddrW-1:0] w0_addr, w1_addr;
  logic [63:0] w0_hdr, w1_hdr;

  // APB: marker register at index 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, marker} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= MarkerReset;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      marker <= pwdata[7:0];
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data = out_r;

  // Header view of the captured bytes.
  logic [15:0] h_size;
  logic [31:0] h_key;
  logic [7:0] h_kind, h_mark;
  logic [CntW+5:0] h_next;
  logic h_ok;
  assign h_key = hdr[31:0];
  assign h_size = hdr[47:32];
  assign h_kind = hdr[55:48];
  assign h_mark = hdr[63:56];
  assign h_next = (CntW+6)'(pos) + (CntW+6)'(HdrBytes) + (CntW+6)'(h_size);
  assign h_ok = h_mark == marker && h_size != 16'd0 &&
                h_next <= (CntW+6)'(StoreBytes);
  // Header must fit before it is read.
  logic fits8;
  assign fits8 = (CntW+1)'(pos) + (CntW+1)'(HdrBytes) <= (CntW+1)'(StoreBytes);

  // Append fit test.
  logic [CntW+1:0] app_end;
  assign app_end = (CntW+2)'(pos) + (CntW+2)'(2*HdrBytes) + (CntW+2)'(cur.length);

  function automatic logic [63:0] mk_hdr(input logic [31:0] k, input logic [15:0] s,
                                          input logic [7:0] kd, input logic [7:0] m);
    mk_hdr = {m, kd, s, k};
  endfunction

  // First state and status of an incoming transaction.
  state_t start_state;
  logic [2:0] start_status;
  always_comb begin
    start_state = S_DONE;
    start_status = ST_BAD_REQ;
    unique case (req.data.cmd)
      CMD_LOOKUP, CMD_REMOVE: begin
        if (req.data.key != 32'd0) start_state = S_HADDR;
      end
      CMD_EMPLACE: begin
        if (req.data.key != 32'd0 && req.data.length != 10'd0) start_state = S_HADDR;
      end
      CMD_FORMAT: begin
        start_status = ST_OK;
        start_state = S_WRHDR;
      end
      CMD_READ, CMD_WRITE: begin
        if (CntW'(req.data.byte_addr) < StoreLen) start_state = S_BYTE;
      end
      default: ;
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_addr = pos[AddrW-1:0];
    mem_wdata = 8'hFF;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_HADDR: begin
        mem_addr = pos[AddrW-1:0] + AddrW'(bi);
      end
      S_WRHDR: begin
        mem_we = 1'b1;
        if (wq[0]) begin
          mem_addr = w0_addr + AddrW'(bi);
          mem_wdata = w0_hdr[8*bi +: 8];
        end else begin
          mem_addr = w1_addr + AddrW'(bi);
          mem_wdata = w1_hdr[8*bi +: 8];
        end
      end
      S_BYTE: begin
        mem_addr = cur.byte_addr[AddrW-1:0];
        mem_we = (cur.cmd == CMD_WRITE);
        mem_wdata = cur.byte_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pos <= '0;
      bi <= '0;
      wq <= '0;
      walk <= W_KEY;
      found <= 1'b0;
      ffound <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          pos <= pos + 1'b1;
          if (pos == StoreLen - 1'b1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            out_r <= {start_status, 3'd0, 10'd0, 10'd0, 8'd0};
            pos <= '0;
            bi <= '0;
            wq <= (req.data.cmd == CMD_FORMAT) ? 2'b01 : 2'b00;
            walk <= W_KEY;
            found <= 1'b0;
            ffound <= 1'b0;
            // Format writes an end header at address 0.
            w0_addr <= '0;
            w0_hdr <= mk_hdr(32'd0, 16'd0, 8'd0, marker);
            state <= start_state;
          end
        end
        S_HADDR: begin
          // Out-of-store header ends the walk.
          if (!fits8) begin
            state <= S_DECIDE;
          end else begin
            state <= S_HCAP;
          end
        end
        S_HCAP: begin
          hdr[8*bi +: 8] <= mem_rdata;
          bi <= bi + 1'b1;
          state <= (bi == 3'd7) ? S_EVAL : S_HADDR;
        end
        S_EVAL: begin
          bi <= '0;
          if (!h_ok) begin
            state <= S_DECIDE;
          end else if (walk == W_KEY && h_key == cur.key) begin
            found <= 1'b1;
            fa <= pos[AddrW-1:0];
            fa_size <= h_size;
            fa_kind <= h_kind;
            state <= S_DECIDE;
          end else if (walk == W_FREE && h_key == 32'd0 && h_kind == 8'd0 &&
                       h_size >= 16'(cur.length)) begin
            ffound <= 1'b1;
            fb <= pos[AddrW-1:0];
            state <= S_DECIDE;
          end else begin
            pos <= h_next[CntW-1:0];
            state <= S_HADDR;
          end
        end
        S_DECIDE: begin
          bi <= '0;
          unique case (walk)
            W_KEY: begin
              if (cur.cmd == CMD_LOOKUP || cur.cmd == CMD_REMOVE) begin
                if (!found) begin
                  out_r.status <= ST_NOT_FOUND;
                  state <= S_DONE;
                end else begin
                  out_r.status <= (cur.cmd == CMD_LOOKUP &&
                                   fa_kind != {5'd0, cur.kind}) ? ST_WRONG_KIND : ST_OK;
                  out_r.found_kind <= fa_kind[2:0];
                  out_r.payload_addr <= fa + AddrW'(HdrBytes);
                  out_r.payload_size <= fa_size[9:0];
                  if (cur.cmd == CMD_REMOVE) begin
                    w0_addr <= fa;
                    w0_hdr <= mk_hdr(32'd0, fa_size, 8'd0, marker);
                    wq <= 2'b01;
                    state <= S_WRHDR;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end else if (found && fa_size >= 16'(cur.length)) begin
                out_r.status <= ST_OK;
                out_r.found_kind <= cur.kind;
                out_r.payload_addr <= fa + AddrW'(HdrBytes);
                out_r.payload_size <= fa_size[9:0];
                w0_addr <= fa;
                w0_hdr <= mk_hdr(cur.key, fa_size, {5'd0, cur.kind}, marker);
                wq <= 2'b01;
                state <= S_WRHDR;
              end else begin
                walk <= W_FREE;
                pos <= '0;
                state <= S_HADDR;
              end
            end
            W_FREE: begin
              if (ffound) begin
                out_r.status <= ST_OK;
                out_r.found_kind <= cur.kind;
                out_r.payload_addr <= fb + AddrW'(HdrBytes);
                out_r.payload_size <= hdr[41:32];
                w1_addr <= fb;
                w1_hdr <= mk_hdr(cur.key, h_size, {5'd0, cur.kind}, marker);
                w0_addr <= fa;
                w0_hdr <= mk_hdr(32'd0, fa_size, 8'd0, marker);
                wq <= {1'b1, found};
                state <= S_WRHDR;
              end else begin
                // The free walk stopped at the chain end: pos holds it.
                walk <= W_END;
                state <= S_DECIDE;
              end
            end
            default: begin
              if (app_end > (CntW+2)'(StoreBytes)) begin
                out_r.status <= ST_NO_SPACE;
                state <= S_DONE;
              end else begin
                out_r.status <= ST_OK;
                out_r.found_kind <= cur.kind;
                out_r.payload_addr <= pos[AddrW-1:0] + AddrW'(HdrBytes);
                out_r.payload_size <= cur.length;
                w1_addr <= pos[AddrW-1:0];
                w1_hdr <= mk_hdr(cur.key, {6'd0, cur.length}, {5'd0, cur.kind}, marker);
                w0_addr <= fa;
                w0_hdr <= mk_hdr(32'd0, fa_size, 8'd0, marker);
                wq <= {1'b1, found};
                walk <= W_KEY;
                state <= S_WRHDR;
              end
            end
          endcase
        end
        S_WRHDR: begin
          bi <= bi + 1'b1;
          if (bi == 3'd7) begin
            if (wq[0]) begin
              wq[0] <= 1'b0;
              if (!wq[1]) state <= S_DONE;
            end else if (cur.cmd == CMD_EMPLACE && walk == W_KEY && !ffound) begin
              // Append: end header goes right after the new payload.
              w1_addr <= w1_addr + AddrW'(HdrBytes) + cur.length;
              w1_hdr <= mk_hdr(32'd0, 16'd0, 8'd0, marker);
              walk <= W_END;
            end else begin
              wq[1] <= 1'b0;
              state <= S_DONE;
            end
          end
        end
        S_BYTE: begin
          out_r.status <= ST_OK;
          state <= (cur.cmd == CMD_READ) ? S_BCAP : S_DONE;
        end
        S_BCAP: begin
          out_r.read_data <= mem_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
